[src/rgbhsl_pkg.sv]
// Shared types, constants and divider step function for the RGB to HSL converter.
package rgbhsl_pkg;

	// Channel and field widths
	localparam int CH_W    = 8;
	localparam int SUM_W   = CH_W + 1;
	localparam int DIFF_W  = CH_W + 1;

	// Divider geometry: quotient is known to fit in eight bits
	localparam int QUO_W      = 8;
	localparam int REM_W      = 17;
	localparam int DEN_W      = 10;
	localparam int SH_W       = $clog2(QUO_W);
	localparam int DIV_STAGES = QUO_W / 2;
	localparam int DIV_LAST   = DIV_STAGES - 1;

	typedef logic [REM_W-1:0] rem_t;
	typedef logic [DEN_W-1:0] den_t;
	typedef logic [QUO_W-1:0] quo_t;

	// Dominant channel, which picks the hue sector
	typedef enum logic [1:0] {
		SECT_RED   = 2'd0,
		SECT_GREEN = 2'd1,
		SECT_BLUE  = 2'd2
	} sect_t;

	// Pixel transaction
	typedef struct packed {
		logic [CH_W-1:0] red_in;
		logic [CH_W-1:0] green_in;
		logic [CH_W-1:0] blue_in;
	} rgb_t;

	// Result transaction
	typedef struct packed {
		logic [CH_W-1:0] hue_out;
		logic [CH_W-1:0] sat_out;
		logic [CH_W-1:0] light_out;
	} hsl_t;

	// Channel ordering result
	typedef struct packed {
		logic signed [DIFF_W-1:0] diff;
		logic [SUM_W-1:0]         sum;
		logic [CH_W-1:0]          delta;
		logic [CH_W-1:0]          light;
		sect_t                    sect;
		logic                     grey;
	} prep_t;

	// Dividend and divisor pairs for both divisions
	typedef struct packed {
		rem_t            num_h;
		den_t            den_h;
		rem_t            num_s;
		den_t            den_s;
		logic [CH_W-1:0] light;
		logic            grey;
	} setup_t;

	// Divider pipeline word
	typedef struct packed {
		rem_t            rem_h;
		den_t            den_h;
		quo_t            q_h;
		rem_t            rem_s;
		den_t            den_s;
		quo_t            q_s;
		logic [CH_W-1:0] light;
		logic            grey;
	} divw_t;

	typedef struct packed {
		rem_t rem;
		logic qbit;
	} step_t;

	// One restoring division step against the divisor shifted up by sh
	function automatic step_t div_step(input rem_t rem, input den_t den,
		input logic [SH_W-1:0] sh);
		step_t        res;
		rem_t         dsh;
		logic [REM_W:0] trial;
		dsh      = {{(REM_W-DEN_W){1'b0}}, den} << sh;
		trial    = {1'b0, rem} - {1'b0, dsh};
		res.qbit = ~trial[REM_W];
		res.rem  = res.qbit ? trial[REM_W-1:0] : rem;
		return res;
	endfunction

endpackage

[src/rgbhsl_prep.sv]
// First stage: channel ordering, dominant channel, spread, sum and lightness.
module rgbhsl_prep (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pix_valid,
	output logic                pix_stall,
	input  rgbhsl_pkg::rgb_t    pix,
	output logic                prep_valid,
	input  logic                prep_stall,
	output rgbhsl_pkg::prep_t   prep
);
	import rgbhsl_pkg::*;

	logic [CH_W-1:0] r, g, b, hi, lo;
	logic            en;
	logic            vld_s1;
	prep_t           nxt;
	prep_t           prep_s1;

	assign r = pix.red_in;
	assign g = pix.green_in;
	assign b = pix.blue_in;

	// Order the channels, red winning ties, then green
	always_comb begin
		if (r > g) begin
			hi = (r > b) ? r : b;
			lo = (g < b) ? g : b;
		end else begin
			hi = (g > b) ? g : b;
			lo = (r < b) ? r : b;
		end
	end

	// Pick the sector and its channel difference
	always_comb begin
		nxt.sum   = {1'b0, hi} + {1'b0, lo};
		nxt.delta = hi - lo;
		nxt.light = CH_W'(({1'b0, nxt.sum} + {{SUM_W{1'b0}}, 1'b1}) >> 1);
		nxt.grey  = (hi == lo);
		if (r == hi) begin
			nxt.sect = SECT_RED;
			nxt.diff = $signed({1'b0, g}) - $signed({1'b0, b});
		end else if (g == hi) begin
			nxt.sect = SECT_GREEN;
			nxt.diff = $signed({1'b0, b}) - $signed({1'b0, r});
		end else begin
			nxt.sect = SECT_BLUE;
			nxt.diff = $signed({1'b0, r}) - $signed({1'b0, g});
		end
	end

	// Advance when empty or when the next stage moves
	assign en        = ~vld_s1 | ~prep_stall;
	assign pix_stall = ~en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prep_s1 <= nxt;
		end
	end

	assign prep_valid = vld_s1;
	assign prep       = prep_s1;

endmodule

[src/rgbhsl_setup.sv]
// Second stage: build dividends and divisors for hue and saturation.
module rgbhsl_setup (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 prep_valid,
	output logic                 prep_stall,
	input  rgbhsl_pkg::prep_t    prep,
	output logic                 setup_valid,
	input  logic                 setup_stall,
	output rgbhsl_pkg::setup_t   setup
);
	import rgbhsl_pkg::*;

	logic [9:0]        base;
	logic signed [11:0] t_raw;
	logic [10:0]       six_delta;
	logic [11:0]       t_wrap;
	logic [10:0]       t_pos;
	logic [SUM_W-1:0]  d_sel;
	logic              en;
	logic              vld_s2;
	setup_t            nxt;
	setup_t            setup_s2;

	// Sector offset: zero, two or four spreads
	always_comb begin
		case (prep.sect)
			SECT_RED:   base = '0;
			SECT_GREEN: base = {1'b0, prep.delta, 1'b0};
			SECT_BLUE:  base = {prep.delta, 2'b00};
			default:    base = '0;
		endcase
	end

	// Wrap a negative hue by a full circle of six spreads
	always_comb begin
		t_raw     = {{3{prep.diff[DIFF_W-1]}}, prep.diff} + $signed({2'b00, base});
		six_delta = {1'b0, prep.delta, 2'b00} + {2'b00, prep.delta, 1'b0};
		t_wrap    = t_raw[11] ? (unsigned'(t_raw) + {1'b0, six_delta})
		                      : unsigned'(t_raw);
		t_pos     = t_wrap[10:0];
	end

	// Dark half divides by the sum, light half by its complement to 511
	always_comb begin
		d_sel     = prep.sum[SUM_W-1] ? SUM_W'(9'd511 - prep.sum) : prep.sum;
		nxt.num_h = REM_W'({6'b0, t_pos} * 17'd85) + {{(REM_W-CH_W){1'b0}}, prep.delta};
		nxt.den_h = {1'b0, prep.delta, 1'b0};
		nxt.num_s = REM_W'({9'b0, prep.delta} * 17'd510)
		          + {{(REM_W-SUM_W){1'b0}}, d_sel};
		nxt.den_s = {d_sel, 1'b0};
		nxt.light = prep.light;
		nxt.grey  = prep.grey;
	end

	assign en         = ~vld_s2 | ~setup_stall;
	assign prep_stall = ~en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= prep_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			setup_s2 <= nxt;
		end
	end

	assign setup_valid = vld_s2;
	assign setup       = setup_s2;

	// Hue quotient must fit in eight bits
	a_hue_fits: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && !setup_s2.grey |-> ({1'b0, setup_s2.num_h} < {setup_s2.den_h, 8'b0}))
		else $error("hue dividend overflows the quotient");

endmodule

[src/rgbhsl_div.sv]
// Pipelined restoring divider, two quotient bits per stage, hue and saturation lanes.
module rgbhsl_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 setup_valid,
	output logic                 setup_stall,
	input  rgbhsl_pkg::setup_t   setup,
	output logic                 hsl_valid,
	input  logic                 hsl_stall,
	output rgbhsl_pkg::hsl_t     hsl
);
	import rgbhsl_pkg::*;

	divw_t                 src   [DIV_STAGES];
	divw_t                 nxt   [DIV_STAGES];
	divw_t                 div_s [DIV_STAGES];
	logic [DIV_STAGES-1:0] vld_s;
	logic [DIV_STAGES-1:0] vin;
	logic [DIV_STAGES-1:0] en;

	// Load the dividends as the starting remainders
	assign src[0] = '{rem_h: setup.num_h, den_h: setup.den_h, q_h: '0,
	                  rem_s: setup.num_s, den_s: setup.den_s, q_s: '0,
	                  light: setup.light, grey: setup.grey};
	assign vin[0] = setup_valid;

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		step_t h_hi, h_lo, s_hi, s_lo;

		if (k > 0) begin : g_link
			assign src[k] = div_s[k-1];
			assign vin[k] = vld_s[k-1];
		end

		// Advance when empty or when the next stage moves
		if (k == DIV_LAST) begin : g_tail
			assign en[k] = ~vld_s[k] | ~hsl_stall;
		end else begin : g_body
			assign en[k] = ~vld_s[k] | en[k+1];
		end

		// Two restoring steps per lane
		always_comb begin
			h_hi = div_step(src[k].rem_h, src[k].den_h, SH_W'(QUO_W - 1 - 2 * k));
			h_lo = div_step(h_hi.rem, src[k].den_h, SH_W'(QUO_W - 2 - 2 * k));
			s_hi = div_step(src[k].rem_s, src[k].den_s, SH_W'(QUO_W - 1 - 2 * k));
			s_lo = div_step(s_hi.rem, src[k].den_s, SH_W'(QUO_W - 2 - 2 * k));
			nxt[k]       = src[k];
			nxt[k].rem_h = h_lo.rem;
			nxt[k].q_h   = {src[k].q_h[QUO_W-3:0], h_hi.qbit, h_lo.qbit};
			nxt[k].rem_s = s_lo.rem;
			nxt[k].q_s   = {src[k].q_s[QUO_W-3:0], s_hi.qbit, s_lo.qbit};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en[k]) begin
				vld_s[k] <= vin[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				div_s[k] <= nxt[k];
			end
		end
	end

	assign setup_stall = ~en[0];

	// Grey pixels carry no hue and no saturation
	assign hsl_valid     = vld_s[DIV_LAST];
	assign hsl.hue_out   = div_s[DIV_LAST].grey ? '0 : div_s[DIV_LAST].q_h;
	assign hsl.sat_out   = div_s[DIV_LAST].grey ? '0 : div_s[DIV_LAST].q_s;
	assign hsl.light_out = div_s[DIV_LAST].light;

	a_hue_rem: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[DIV_LAST] && !div_s[DIV_LAST].grey
		|-> (div_s[DIV_LAST].rem_h < {{(REM_W-DEN_W){1'b0}}, div_s[DIV_LAST].den_h}))
		else $error("hue remainder not below divisor");

	a_sat_rem: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[DIV_LAST] && !div_s[DIV_LAST].grey
		|-> (div_s[DIV_LAST].rem_s < {{(REM_W-DEN_W){1'b0}}, div_s[DIV_LAST].den_s}))
		else $error("saturation remainder not below divisor");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[DIV_LAST] && hsl_stall |=> vld_s[DIV_LAST] && $stable(div_s[DIV_LAST]))
		else $error("stalled result lost or changed");

endmodule

[src/rgb_to_hsl_8bit.sv]
// RGB to HSL converter: six-stage pipeline of ordering, setup and two dividers.
// Throughput: one pixel per cycle while hsl_stall is low.
// The two pipelined restoring dividers set the depth.
// A stalled output holds all stages behind it; bubbles are squeezed out.
// Reset clears only the stage valid bits; the datapath registers are not reset.
module rgb_to_hsl_8bit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pix_valid,
	output logic               pix_stall,
	input  rgbhsl_pkg::rgb_t   pix,
	output logic               hsl_valid,
	input  logic               hsl_stall,
	output rgbhsl_pkg::hsl_t   hsl
);
	import rgbhsl_pkg::*;

	logic   prep_valid, prep_stall;
	logic   setup_valid, setup_stall;
	prep_t  prep;
	setup_t setup;

	rgbhsl_prep u_prep (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix_valid  (pix_valid),
		.pix_stall  (pix_stall),
		.pix        (pix),
		.prep_valid (prep_valid),
		.prep_stall (prep_stall),
		.prep       (prep)
	);

	rgbhsl_setup u_setup (
		.clk         (clk),
		.arst_n      (arst_n),
		.prep_valid  (prep_valid),
		.prep_stall  (prep_stall),
		.prep        (prep),
		.setup_valid (setup_valid),
		.setup_stall (setup_stall),
		.setup       (setup)
	);

	rgbhsl_div u_div (
		.clk         (clk),
		.arst_n      (arst_n),
		.setup_valid (setup_valid),
		.setup_stall (setup_stall),
		.setup       (setup),
		.hsl_valid   (hsl_valid),
		.hsl_stall   (hsl_stall),
		.hsl         (hsl)
	);

endmodule
